/* sv/lpqs_pkg.sv */
// ----------------------------------------------------------------------------
// lpqs_pkg
// Shared types and constants of the quarter-scan LED panel driver: command
// word passed from front to back, back-end status, sizes and the off pattern.
// ----------------------------------------------------------------------------
package lpqs_pkg;

    // sizes fixed by the panel geometry
    localparam int BYTES_PER_ROW_DEF = 16;
    localparam int SCAN_ROWS         = 4;
    localparam int ROW_W             = 2;
    localparam int COL_W             = 4;
    localparam int BIT_W             = 3;
    localparam int QUEUE_DEPTH       = 2;   // power of two, pointers wrap freely

    // all pixels off
    localparam logic [7:0] BYTE_OFF = 8'hFF;

    // item kinds on the mode input
    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_SCAN  = 1'b1
    } mode_t;

    // classified command word held in the queue
    typedef struct packed {
        logic             is_scan;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [BIT_W-1:0] bit_idx;
        logic             value;
    } cmd_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic             idle;
        logic [ROW_W-1:0] row_cnt;
    } back_status_t;

endpackage

/* sv/lpqs_ram.sv */
// ----------------------------------------------------------------------------
// lpqs_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lpqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/lpqs_front.sv */
// ----------------------------------------------------------------------------
// lpqs_front
// Accepts item words, classifies them into pixel writes and scans, works out
// the byte column and bit of a pixel, and queues the command for the back end.
// ----------------------------------------------------------------------------
module lpqs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          mode,
    input  logic [4:0]    pixel_x,
    input  logic [3:0]    pixel_y,
    input  logic          pixel_value,
    output logic          busy,
    output logic          q_valid,
    output lpqs_pkg::cmd_t q_cmd,
    input  logic          q_pop
);

    import lpqs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    cmd_t             cmd_in;
    logic             push;

    // classify: row y%4, column (3-y/4)+4*(x/8), bit 7-x%8
    always_comb
    begin
        cmd_in.is_scan = (mode == MODE_SCAN);
        cmd_in.row     = pixel_y[1:0];
        cmd_in.col     = {pixel_x[4:3], ~pixel_y[3:2]};
        cmd_in.bit_idx = ~pixel_x[2:0];
        cmd_in.value   = pixel_value;
    end

    assign busy    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* sv/lpqs_back.sv */
// ----------------------------------------------------------------------------
// lpqs_back
// Executes queued commands against the scan memory: read-modify-write of one
// bit for a pixel, or a sixteen-byte row read-out followed by a row advance.
// ----------------------------------------------------------------------------
module lpqs_back #(
    parameter int BYTES_PER_ROW = lpqs_pkg::BYTES_PER_ROW_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  lpqs_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output logic                        strobe,
    output logic [lpqs_pkg::ROW_W-1:0]  row_address,
    output logic [7:0]                  data_byte,
    output logic                        last_of_row,
    output lpqs_pkg::back_status_t      status
);

    import lpqs_pkg::*;

    localparam int DEPTH = SCAN_ROWS * BYTES_PER_ROW;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(BYTES_PER_ROW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_SCAN
    } state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [KW-1:0]    k_reg;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_vld_reg;
    logic             rd_last_reg;
    logic [ROW_W-1:0] rd_row_reg;
    logic             hit_reg;

    logic [AW-1:0]    ram_addr;
    logic             ram_we;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;
    logic [7:0]       old_byte;
    logic [7:0]       mask;
    logic             k_last;

    assign k_last = (k_reg == KW'(BYTES_PER_ROW - 1));
    assign q_pop  = (state_reg == ST_IDLE) && q_valid;

    // memory address: scan walks the current row, pixel uses its own spot
    always_comb
    begin
        case (state_reg)
            ST_SCAN:
            begin
                ram_addr = AW'(row_cnt_reg) * AW'(BYTES_PER_ROW) + AW'(k_reg);
            end
            default:
            begin
                ram_addr = AW'(cmd_reg.row) * AW'(BYTES_PER_ROW) + AW'(cmd_reg.col);
            end
        endcase
    end

    // bit update of a pixel write; unwritten bytes read as all off
    assign old_byte  = hit_reg ? ram_rdata : BYTE_OFF;
    assign mask      = 8'(1) << cmd_reg.bit_idx;
    assign ram_wdata = cmd_reg.value ? (old_byte | mask) : (old_byte & ~mask);
    assign ram_we    = (state_reg == ST_PIX_WR);

    lpqs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_scan_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // sequencer, row counter, written marks and read-out strobes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            row_cnt_reg <= '0;
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= (state_reg == ST_SCAN);
            rd_last_reg <= (state_reg == ST_SCAN) && k_last;
            case (state_reg)
                ST_IDLE:
                begin
                    k_reg <= '0;
                    if (q_valid)
                    begin
                        state_reg <= q_cmd.is_scan ? ST_SCAN : ST_PIX_RD;
                    end
                end
                ST_PIX_RD:
                begin
                    state_reg <= ST_PIX_WR;
                end
                ST_PIX_WR:
                begin
                    valid_reg[ram_addr] <= 1'b1;
                    state_reg           <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_last)
                    begin
                        row_cnt_reg <= row_cnt_reg + 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload alongside the memory read
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        hit_reg    <= valid_reg[ram_addr];
        rd_row_reg <= row_cnt_reg;
    end

    // result word
    assign strobe      = rd_vld_reg;
    assign row_address = rd_row_reg;
    assign data_byte   = hit_reg ? ram_rdata : BYTE_OFF;
    assign last_of_row = rd_last_reg;

    assign status.idle    = (state_reg == ST_IDLE);
    assign status.row_cnt = row_cnt_reg;

endmodule

/* sv/led_panel_quarter_scan_driver_core.sv */
// ----------------------------------------------------------------------------
// led_panel_quarter_scan_driver_core
// Quarter-scan driver for a 32x16 single-color LED panel: pixel writes into a
// scan memory and row read-outs of sixteen bytes with row address and latch.
//
//   channel | dir | handshake              | word
//   --------+-----+------------------------+----------------------------------
//   item    | in  | start && !busy         | mode, pixel_x, pixel_y, pixel_value
//   result  | out | strobe, one cycle each | row_address, data_byte, last_of_row
//
// A scan leaves the queue with a dispatch step, then reads one byte a cycle
// through the single memory port, each byte appearing in the cycle after its
// read. A pixel write steps through dispatch, read and write back. Up to two
// words wait in the queue; busy is high when it is full. Reset needs no
// clearing pass: per-byte written marks make unwritten bytes read as all off.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module led_panel_quarter_scan_driver_core #(
    parameter int BYTES_PER_ROW = lpqs_pkg::BYTES_PER_ROW_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        mode,
    input  logic [4:0]                  pixel_x,
    input  logic [3:0]                  pixel_y,
    input  logic                        pixel_value,
    output logic                        strobe,
    output logic [lpqs_pkg::ROW_W-1:0]  row_address,
    output logic [7:0]                  data_byte,
    output logic                        last_of_row
);

    import lpqs_pkg::*;

    logic         q_valid;
    logic         q_pop;
    cmd_t         q_cmd;
    back_status_t back_status;

    // classify and queue
    lpqs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_value (pixel_value),
        .busy        (busy),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop)
    );

    // execute against the scan memory
    lpqs_back #(
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .strobe      (strobe),
        .row_address (row_address),
        .data_byte   (data_byte),
        .last_of_row (last_of_row),
        .status      (back_status)
    );

    // bytes of a row come out without gaps
    a_row_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_of_row) |=> strobe)
        else $error("row read-out has a gap");

    // strobe drops after the last byte of a row, so rows never come back to back
    a_row_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_of_row) |=> !strobe)
        else $error("rows emitted back to back");

    // the row counter has moved on by the time the last byte shows
    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_of_row) |->
            (back_status.row_cnt == ROW_W'(row_address + 2'd1)))
        else $error("row counter did not advance after a row");

    // the back end is still mid-row while a row is coming out
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_of_row) |-> !back_status.idle)
        else $error("back end idle in the middle of a row");

endmodule

/* dv/led_panel_quarter_scan_driver_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_panel_quarter_scan_driver_core_tb
// Self-checking bench for the quarter-scan LED panel driver. A scoreboard
// keeps its own copy of the scan memory and row counter. Every accepted pixel
// write updates that copy. Every accepted scan queues the sixteen bytes due
// for the current row. Each strobed byte is checked against the oldest byte
// due. The stimulus is a directed opening followed by random writes and scans
// with random sender gaps.
// ----------------------------------------------------------------------------
module led_panel_quarter_scan_driver_core_tb;

    import lpqs_pkg::*;

    localparam int ROW_BYTES   = BYTES_PER_ROW_DEF;
    localparam int RAND_ITEMS  = 180;
    localparam int QUIET_LIMIT = 2000;   // cycles with no word moving
    localparam int DRAIN_WAIT  = 40;

    // one byte expected on the result side
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [7:0]       data;
        logic             last;
    } row_byte_t;

    // scan memory and row counter copy, plus the bytes still due
    class row_byte_checker;
        logic [7:0]       panel_mem [SCAN_ROWS][ROW_BYTES];
        logic [ROW_W-1:0] scan_row;
        row_byte_t        due_bytes [$];
        int               fail_cnt;

        function new();
            foreach (panel_mem[r, c]) panel_mem[r][c] = BYTE_OFF;
            scan_row = '0;
            fail_cnt = 0;
        endfunction

        // accepted input word: update the memory or queue a whole row
        function void note_item(logic m, logic [4:0] x, logic [3:0] y, logic v);
            int        xi;
            int        yi;
            int        r;
            int        c;
            row_byte_t w;
            xi = x;
            yi = y;
            if (m == MODE_PIXEL) begin
                r = yi % 4;
                c = (3 - yi / 4) + 4 * (xi / 8);
                if (c < ROW_BYTES)
                    panel_mem[r][c][7 - xi % 8] = v;
            end
            else begin
                for (int k = 0; k < ROW_BYTES; k++) begin
                    w.row  = scan_row;
                    w.data = panel_mem[scan_row][k];
                    w.last = (k == ROW_BYTES - 1);
                    due_bytes.push_back(w);
                end
                scan_row = scan_row + 1'b1;
            end
        endfunction

        // strobed result word against the oldest byte due
        function void check_result(logic [ROW_W-1:0] row, logic [7:0] data, logic last);
            row_byte_t w;
            if (due_bytes.size() == 0) begin
                $display("%0t: unexpected byte row %0d data %02h last %0b",
                         $realtime, row, data, last);
                fail_cnt++;
                return;
            end
            w = due_bytes.pop_front();
            if (row !== w.row) begin
                $display("%0t: row_address expected %0d got %0d", $realtime, w.row, row);
                fail_cnt++;
            end
            if (data !== w.data) begin
                $display("%0t: data_byte expected %02h got %02h", $realtime, w.data, data);
                fail_cnt++;
            end
            if (last !== w.last) begin
                $display("%0t: last_of_row expected %0b got %0b", $realtime, w.last, last);
                fail_cnt++;
            end
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             mode;
    logic [4:0]       pixel_x;
    logic [3:0]       pixel_y;
    logic             pixel_value;
    logic             strobe;
    logic [ROW_W-1:0] row_address;
    logic [7:0]       data_byte;
    logic             last_of_row;

    row_byte_checker sb;
    int              quiet_cnt;

    led_panel_quarter_scan_driver_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_value (pixel_value),
        .strobe      (strobe),
        .row_address (row_address),
        .data_byte   (data_byte),
        .last_of_row (last_of_row)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // input word taken
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_item(mode, pixel_x, pixel_y, pixel_value);
    end

    // result word taken
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(row_address, data_byte, last_of_row);
    end

    // watchdog on cycles where no word moves
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((start && !busy) || strobe)
                quiet_cnt <= 0;
            else
                quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= QUIET_LIMIT) begin
                $display("%0t: timeout, no progress", $realtime);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // one input word; each cycle the sender may idle first, about 15 in 100
    task automatic send_item(input logic m, input logic [4:0] x, input logic [3:0] y,
                             input logic v, input bit may_idle);
        while (may_idle && $urandom_range(99) < 15)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start       <= 1'b1;
        mode        <= m;
        pixel_x     <= x;
        pixel_y     <= y;
        pixel_value <= v;
        do @(posedge clk); while (busy);
    endtask

    task automatic write_px(input logic [4:0] x, input logic [3:0] y, input logic v);
        send_item(MODE_PIXEL, x, y, v, 1'b0);
    endtask

    initial
    begin
        bit idle_ok;
        sb          = new();
        quiet_cnt   = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_PIXEL;
        pixel_x     = '0;
        pixel_y     = '0;
        pixel_value = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: blank row, field extremes, every row, ignored scan fields
        send_item(MODE_SCAN, 5'd31, 4'd15, 1'b0, 1'b0);
        write_px(5'd0,  4'd0,  1'b0);
        write_px(5'd31, 4'd15, 1'b0);
        write_px(5'd7,  4'd4,  1'b0);
        write_px(5'd8,  4'd11, 1'b0);
        write_px(5'd16, 4'd3,  1'b0);
        write_px(5'd23, 4'd9,  1'b0);
        write_px(5'd0,  4'd0,  1'b1);   // set back to off
        write_px(5'd0,  4'd0,  1'b0);
        send_item(MODE_SCAN, 5'd0, 4'd0, 1'b1, 1'b0);
        send_item(MODE_SCAN, 5'd0, 4'd0, 1'b0, 1'b0);
        send_item(MODE_SCAN, 5'd31, 4'd0, 1'b1, 1'b0);
        send_item(MODE_SCAN, 5'd0, 4'd15, 1'b0, 1'b0);   // row counter wraps
        write_px(5'd31, 4'd15, 1'b1);
        write_px(5'd24, 4'd12, 1'b0);
        send_item(MODE_SCAN, 5'd21, 4'd10, 1'b1, 1'b0);
        send_item(MODE_SCAN, 5'd10, 4'd5,  1'b0, 1'b0);
        send_item(MODE_SCAN, 5'd5,  4'd6,  1'b1, 1'b0);
        send_item(MODE_SCAN, 5'd2,  4'd1,  1'b0, 1'b0);

        // random writes and scans; a middle stretch runs without gaps
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            idle_ok = (i < 60) || (i >= 120);
            send_item(($urandom_range(99) < 25) ? MODE_SCAN : MODE_PIXEL,
                      5'($urandom_range(31)), 4'($urandom_range(15)),
                      1'($urandom_range(1)), idle_ok);
        end

        @(negedge clk);
        start <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.fail_cnt == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
